// ----- hdl/touch_sample_scaler_events_unit_assert.svh -----
// ----------------------------------------------------------------------------
// touch sample scaler assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_SCALER_EVENTS_UNIT_ASSERT_SVH
`define TOUCH_SAMPLE_SCALER_EVENTS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tsse_pkg.sv -----
// ----------------------------------------------------------------------------
// touch sample scaler package
// widths, codes, calibration defaults and control types
// ----------------------------------------------------------------------------
package tsse_pkg;

    // raw sample assembly
    localparam int RAW_BITS  = 12;
    localparam int HI_BITS   = 7;
    localparam int LOW_BITS  = RAW_BITS - HI_BITS;

    // calibration and arithmetic widths
    localparam int CAL_W     = 12;
    localparam int DIFF_W    = ((RAW_BITS > CAL_W) ? RAW_BITS : CAL_W) + 1;
    localparam int RNG_W     = CAL_W + 1;
    localparam int PROD_W    = DIFF_W + RNG_W;
    localparam int MAG_W     = PROD_W - 1;
    localparam int DIV_STEPS = (MAG_W + 1) / 2;
    localparam int QUO_W     = 2 * DIV_STEPS;
    localparam int SUM_W     = QUO_W + 2;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int KIND_W    = 2;
    localparam int REG_IDX_W = 3;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_X   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_Y   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BTN = 2'd2;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PHYS_X_START,
        REG_PHYS_X_END,
        REG_PHYS_Y_START,
        REG_PHYS_Y_END,
        REG_DISP_X_MIN,
        REG_DISP_X_MAX,
        REG_DISP_Y_MIN,
        REG_DISP_Y_MAX
    } reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] phys_x_start;
        logic [CAL_W-1:0] phys_x_end;
        logic [CAL_W-1:0] phys_y_start;
        logic [CAL_W-1:0] phys_y_end;
        logic [CAL_W-1:0] disp_x_min;
        logic [CAL_W-1:0] disp_x_max;
        logic [CAL_W-1:0] disp_y_min;
        logic [CAL_W-1:0] disp_y_max;
    } cal_t;

    localparam cal_t CAL_RESET = '{
        phys_x_start: 12'd3856,
        phys_x_end:   12'd176,
        phys_y_start: 12'd3856,
        phys_y_end:   12'd176,
        disp_x_min:   12'd0,
        disp_x_max:   12'd480,
        disp_y_min:   12'd0,
        disp_y_max:   12'd640
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_ADJ,
        ST_PLAN,
        ST_EMIT_X,
        ST_EMIT_Y,
        ST_EMIT_BTN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              mul;
        logic              div_start;
        logic              div_step;
        logic              adj;
        logic              axis;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              btn_val;
        logic              emit_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic pen_up;
        logic motion_ok;
        logic out_free;
    } stat_t;

endpackage

// ----- hdl/tsse_in_if.sv -----
// ----------------------------------------------------------------------------
// touch sample input channel
// valid/ready channel carrying one controller reply set
// ----------------------------------------------------------------------------
interface tsse_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        pen_up;
    logic [15:0] reply_a;
    logic [15:0] reply_b;
    logic [15:0] reply_c;

    modport source (output valid, op, pen_up, reply_a, reply_b, reply_c, input ready);
    modport sink   (input valid, op, pen_up, reply_a, reply_b, reply_c, output ready);
endinterface

// ----- hdl/tsse_out_if.sv -----
// ----------------------------------------------------------------------------
// touch event output channel
// valid/ready channel carrying one input event
// ----------------------------------------------------------------------------
interface tsse_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsse_pkg::KIND_W-1:0] event_kind;
    logic [tsse_pkg::CAL_W-1:0]  event_value;
    logic                        last;

    modport source (output valid, event_kind, event_value, last, input ready);
    modport sink   (input valid, event_kind, event_value, last, output ready);
endinterface

// ----- hdl/tsse_cfg.sv -----
// ----------------------------------------------------------------------------
// touch sample scaler calibration registers
// write-only register file holding the physical and display ranges
// ----------------------------------------------------------------------------
module tsse_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tsse_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tsse_pkg::CAL_W-1:0]     cfg_data,
    output tsse_pkg::cal_t                 cal
);

    tsse_pkg::cal_t cal_reg;
    tsse_pkg::cal_t cal_next;

    // register write decode
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_we)
        begin
            case (tsse_pkg::reg_idx_t'(cfg_index))
                tsse_pkg::REG_PHYS_X_START: cal_next.phys_x_start = cfg_data;
                tsse_pkg::REG_PHYS_X_END:   cal_next.phys_x_end   = cfg_data;
                tsse_pkg::REG_PHYS_Y_START: cal_next.phys_y_start = cfg_data;
                tsse_pkg::REG_PHYS_Y_END:   cal_next.phys_y_end   = cfg_data;
                tsse_pkg::REG_DISP_X_MIN:   cal_next.disp_x_min   = cfg_data;
                tsse_pkg::REG_DISP_X_MAX:   cal_next.disp_x_max   = cfg_data;
                tsse_pkg::REG_DISP_Y_MIN:   cal_next.disp_y_min   = cfg_data;
                tsse_pkg::REG_DISP_Y_MAX:   cal_next.disp_y_max   = cfg_data;
                default:                    cal_next = cal_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= tsse_pkg::CAL_RESET;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

// ----- hdl/tsse_dp.sv -----
// ----------------------------------------------------------------------------
// touch sample scaler datapath
// raw assembly, calibration multiply, radix-4 divider, range check, output reg
// ----------------------------------------------------------------------------
module tsse_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsse_pkg::cmd_t                cmd,
    output tsse_pkg::stat_t               stat,
    input  tsse_pkg::cal_t                cal,
    input  logic                          in_op,
    input  logic                          in_pen_up,
    input  logic [15:0]                   in_reply_a,
    input  logic [15:0]                   in_reply_b,
    input  logic [15:0]                   in_reply_c,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tsse_pkg::KIND_W-1:0]   out_kind,
    output logic [tsse_pkg::CAL_W-1:0]    out_value,
    output logic                          out_last
);

    // captured item
    logic                          op_reg;
    logic                          up_reg;
    logic [tsse_pkg::RAW_BITS-1:0] rx_reg;
    logic [tsse_pkg::RAW_BITS-1:0] ry_reg;

    // arithmetic state
    logic signed [tsse_pkg::PROD_W-1:0] prod_reg;
    logic signed [tsse_pkg::RNG_W-1:0]  span_reg;
    logic [tsse_pkg::QUO_W-1:0]         quo_reg;
    logic [tsse_pkg::CAL_W-1:0]         rem_reg;
    logic [tsse_pkg::CAL_W-1:0]         dvsr_reg;
    logic                               neg_reg;
    logic                               zero_reg;

    // mapped results
    logic [tsse_pkg::CAL_W-1:0] x_val_reg;
    logic [tsse_pkg::CAL_W-1:0] y_val_reg;
    logic                       x_ok_reg;
    logic                       y_ok_reg;

    // output register
    logic                        out_valid_reg;
    logic [tsse_pkg::KIND_W-1:0] out_kind_reg;
    logic [tsse_pkg::CAL_W-1:0]  out_value_reg;
    logic                        out_last_reg;

    logic [tsse_pkg::RAW_BITS-1:0]      raw_sel;
    logic [tsse_pkg::CAL_W-1:0]         ps_sel;
    logic [tsse_pkg::CAL_W-1:0]         pe_sel;
    logic [tsse_pkg::CAL_W-1:0]         dmin_sel;
    logic [tsse_pkg::CAL_W-1:0]         dmax_sel;
    logic signed [tsse_pkg::DIFF_W-1:0] diff;
    logic signed [tsse_pkg::RNG_W-1:0]  rng;
    logic signed [tsse_pkg::RNG_W-1:0]  span;
    logic signed [tsse_pkg::PROD_W-1:0] prod;
    logic [tsse_pkg::PROD_W-1:0]        prod_abs;
    logic [tsse_pkg::RNG_W-1:0]         span_abs;
    logic [tsse_pkg::CAL_W:0]           trial;
    logic [tsse_pkg::CAL_W-1:0]         rem_step;
    logic [tsse_pkg::QUO_W-1:0]         quo_step;
    logic signed [tsse_pkg::QUO_W:0]    quo_s;
    logic signed [tsse_pkg::QUO_W:0]    quo_signed;
    logic signed [tsse_pkg::SUM_W-1:0]  sum;
    logic signed [tsse_pkg::SUM_W-1:0]  dmin_s;
    logic signed [tsse_pkg::SUM_W-1:0]  dmax_s;
    logic                               in_box;
    logic [tsse_pkg::CAL_W-1:0]         emit_value;

    // axis selection of sample and calibration
    always_comb
    begin
        if (cmd.axis)
        begin
            raw_sel  = ry_reg;
            ps_sel   = cal.phys_y_start;
            pe_sel   = cal.phys_y_end;
            dmin_sel = cal.disp_y_min;
            dmax_sel = cal.disp_y_max;
        end
        else
        begin
            raw_sel  = rx_reg;
            ps_sel   = cal.phys_x_start;
            pe_sel   = cal.phys_x_end;
            dmin_sel = cal.disp_x_min;
            dmax_sel = cal.disp_x_max;
        end
    end

    // offset, display range, physical span and their product
    assign diff = $signed({1'b0, (tsse_pkg::DIFF_W-1)'(raw_sel)})
                - $signed({1'b0, (tsse_pkg::DIFF_W-1)'(ps_sel)});
    assign rng  = $signed({1'b0, dmax_sel}) - $signed({1'b0, dmin_sel});
    assign span = $signed({1'b0, pe_sel}) - $signed({1'b0, ps_sel});
    assign prod = (tsse_pkg::PROD_W)'(diff) * (tsse_pkg::PROD_W)'(rng);

    // magnitudes for the unsigned divider
    assign prod_abs = prod_reg[tsse_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign span_abs = span_reg[tsse_pkg::RNG_W-1] ? -span_reg : span_reg;

    // two restoring quotient bits per step
    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_step, quo_step[tsse_pkg::QUO_W-1]};
            quo_step = {quo_step[tsse_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, dvsr_reg})
            begin
                trial       = trial - {1'b0, dvsr_reg};
                quo_step[0] = 1'b1;
            end
            rem_step = trial[tsse_pkg::CAL_W-1:0];
        end
    end

    // signed quotient plus display offset and box check
    assign quo_s      = $signed({1'b0, quo_reg});
    assign quo_signed = neg_reg ? -quo_s : quo_s;
    assign sum        = (tsse_pkg::SUM_W)'(quo_signed) + dmin_s;
    assign dmin_s     = $signed((tsse_pkg::SUM_W)'(dmin_sel));
    assign dmax_s     = $signed((tsse_pkg::SUM_W)'(dmax_sel));
    assign in_box     = !zero_reg && (sum >= dmin_s) && (sum <= dmax_s);

    // item capture and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op;
            up_reg <= in_pen_up;
            rx_reg <= {in_reply_a[tsse_pkg::HI_BITS-1:0],
                       in_reply_b[15 -: tsse_pkg::LOW_BITS]};
            ry_reg <= {in_reply_b[tsse_pkg::HI_BITS-1:0],
                       in_reply_c[15 -: tsse_pkg::LOW_BITS]};
        end
        if (cmd.mul)
        begin
            prod_reg <= prod;
            span_reg <= span;
        end
        if (cmd.div_start)
        begin
            neg_reg  <= prod_reg[tsse_pkg::PROD_W-1] ^ span_reg[tsse_pkg::RNG_W-1];
            zero_reg <= (span_reg == '0);
            quo_reg  <= (tsse_pkg::QUO_W)'(prod_abs[tsse_pkg::MAG_W-1:0]);
            dvsr_reg <= span_abs[tsse_pkg::CAL_W-1:0];
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    // mapped result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_ok_reg <= 1'b0;
            y_ok_reg <= 1'b0;
        end
        else if (cmd.adj)
        begin
            if (cmd.axis)
            begin
                y_ok_reg <= in_box;
            end
            else
            begin
                x_ok_reg <= in_box;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.adj)
        begin
            if (cmd.axis)
            begin
                y_val_reg <= sum[tsse_pkg::CAL_W-1:0];
            end
            else
            begin
                x_val_reg <= sum[tsse_pkg::CAL_W-1:0];
            end
        end
    end

    // event value by kind
    always_comb
    begin
        case (cmd.emit_kind)
            tsse_pkg::KIND_X: emit_value = x_val_reg;
            tsse_pkg::KIND_Y: emit_value = y_val_reg;
            default:          emit_value = (tsse_pkg::CAL_W)'(cmd.btn_val);
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= cmd.emit_kind;
            out_value_reg <= emit_value;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // status back to the controller
    assign stat.op        = op_reg;
    assign stat.pen_up    = up_reg;
    assign stat.motion_ok = x_ok_reg & y_ok_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ----- hdl/tsse_ctrl.sv -----
// ----------------------------------------------------------------------------
// touch sample scaler controller
// sequences capture, per-axis mapping and event emission; holds touch state
// ----------------------------------------------------------------------------
module tsse_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output tsse_pkg::cmd_t  cmd,
    input  tsse_pkg::stat_t stat
);

    tsse_pkg::state_t             state_reg;
    tsse_pkg::state_t             state_next;
    logic [tsse_pkg::STEP_W-1:0]  cnt_reg;
    logic [tsse_pkg::STEP_W-1:0]  cnt_next;
    logic                         axis_reg;
    logic                         axis_next;
    logic                         touching_reg;
    logic                         touching_next;
    logic                         is_press_reg;
    logic                         is_press_next;
    logic                         btn_val_reg;
    logic                         btn_val_next;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsse_pkg::ST_IDLE;
            cnt_reg      <= '0;
            axis_reg     <= 1'b0;
            touching_reg <= 1'b0;
            is_press_reg <= 1'b0;
            btn_val_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            axis_reg     <= axis_next;
            touching_reg <= touching_next;
            is_press_reg <= is_press_next;
            btn_val_reg  <= btn_val_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        axis_next     = axis_reg;
        touching_next = touching_reg;
        is_press_next = is_press_reg;
        btn_val_next  = btn_val_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.btn_val   = btn_val_reg;

        case (state_reg)
            tsse_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = tsse_pkg::ST_DECODE;
                end
            end

            // press, poll with pen lifted, poll while held, or stray poll
            tsse_pkg::ST_DECODE:
            begin
                axis_next = 1'b0;
                if (!stat.op)
                begin
                    is_press_next = 1'b1;
                    btn_val_next  = 1'b1;
                    touching_next = 1'b1;
                    state_next    = tsse_pkg::ST_MUL;
                end
                else if (touching_reg && stat.pen_up)
                begin
                    btn_val_next  = 1'b0;
                    touching_next = 1'b0;
                    state_next    = tsse_pkg::ST_EMIT_BTN;
                end
                else if (touching_reg)
                begin
                    is_press_next = 1'b0;
                    state_next    = tsse_pkg::ST_MUL;
                end
                else
                begin
                    state_next = tsse_pkg::ST_IDLE;
                end
            end

            tsse_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = tsse_pkg::ST_DIV_INIT;
            end

            tsse_pkg::ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = tsse_pkg::ST_DIV;
            end

            tsse_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == (tsse_pkg::STEP_W)'(tsse_pkg::DIV_STEPS - 1))
                begin
                    state_next = tsse_pkg::ST_ADJ;
                end
                else
                begin
                    cnt_next = cnt_reg + (tsse_pkg::STEP_W)'(1);
                end
            end

            // finish this axis, then the other one
            tsse_pkg::ST_ADJ:
            begin
                cmd.adj = 1'b1;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = tsse_pkg::ST_MUL;
                end
                else
                begin
                    state_next = tsse_pkg::ST_PLAN;
                end
            end

            tsse_pkg::ST_PLAN:
            begin
                if (stat.motion_ok)
                begin
                    state_next = tsse_pkg::ST_EMIT_X;
                end
                else if (is_press_reg)
                begin
                    state_next = tsse_pkg::ST_EMIT_BTN;
                end
                else
                begin
                    state_next = tsse_pkg::ST_IDLE;
                end
            end

            tsse_pkg::ST_EMIT_X:
            begin
                cmd.emit_kind = tsse_pkg::KIND_X;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tsse_pkg::ST_EMIT_Y;
                end
            end

            tsse_pkg::ST_EMIT_Y:
            begin
                cmd.emit_kind = tsse_pkg::KIND_Y;
                cmd.emit_last = !is_press_reg;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = is_press_reg ? tsse_pkg::ST_EMIT_BTN : tsse_pkg::ST_IDLE;
                end
            end

            tsse_pkg::ST_EMIT_BTN:
            begin
                cmd.emit_kind = tsse_pkg::KIND_BTN;
                cmd.emit_last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tsse_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tsse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/touch_sample_scaler_events_unit.sv -----
// ----------------------------------------------------------------------------
// touch sample scaler events unit: one item at a time
// shared radix-4 divider: 13 steps per axis, X then Y
// reset clears touch state and control, loads calibration defaults
// ----------------------------------------------------------------------------
module touch_sample_scaler_events_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    tsse_in_if.sink                        in_ch,
    tsse_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [tsse_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tsse_pkg::CAL_W-1:0]     cfg_data
);

    tsse_pkg::cal_t  cal;
    tsse_pkg::cmd_t  cmd;
    tsse_pkg::stat_t stat;

    // calibration registers
    tsse_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // sequencing
    tsse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic and output register
    tsse_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cal        (cal),
        .in_op      (in_ch.op),
        .in_pen_up  (in_ch.pen_up),
        .in_reply_a (in_ch.reply_a),
        .in_reply_b (in_ch.reply_b),
        .in_reply_c (in_ch.reply_c),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_kind   (out_ch.event_kind),
        .out_value  (out_ch.event_value),
        .out_last   (out_ch.last)
    );

endmodule

// ----- hdl/tsse_checker.sv -----
// ----------------------------------------------------------------------------
// touch sample scaler port checker
// port-level properties of the event sequencing, bound to the top level
// ----------------------------------------------------------------------------
`include "touch_sample_scaler_events_unit_assert.svh"

module tsse_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [tsse_pkg::KIND_W-1:0] out_kind,
    input  logic [tsse_pkg::CAL_W-1:0]  out_value,
    input  logic                        out_last
);

    // a stalled event holds
    `TSSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_last), "stalled event changed")

    // no new transaction while an item still has events to deliver
    `TSSE_ASSERT_IMP(a_busy_until_last, out_valid && !out_last, !in_ready, "input ready before last event")

    // an accepted transaction is decoded before the next one
    `TSSE_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "back-to-back input accepted")

    // only defined kinds, and a button event is the last one with a 0/1 value
    `TSSE_ASSERT_IMP(a_kind_known, out_valid, out_kind == tsse_pkg::KIND_X || out_kind == tsse_pkg::KIND_Y || out_kind == tsse_pkg::KIND_BTN, "unknown event kind")
    `TSSE_ASSERT_IMP(a_button_last, out_valid && out_kind == tsse_pkg::KIND_BTN, out_last && out_value[tsse_pkg::CAL_W-1:1] == '0, "bad button event")

endmodule

bind touch_sample_scaler_events_unit tsse_checker u_tsse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.event_kind),
    .out_value (out_ch.event_value),
    .out_last  (out_ch.last)
);
